// ===== design/hebbian_link_strength_update_core_assert.svh =====
// Assertion macros used by the checker file of this block.
`ifndef HEBBIAN_LINK_STRENGTH_UPDATE_CORE_ASSERT_SVH
`define HEBBIAN_LINK_STRENGTH_UPDATE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HLSU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HLSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/hlsu_pkg.sv =====
`timescale 1ns / 1ps

package hlsu_pkg;

    // Fixed point format of strengths, normalized importances and decay rate.
    localparam int FRAC_BITS = 14;
    localparam int FIELD_W   = 16;
    localparam int DECAY_W   = 15;

    // Width of the conjunction and of (ONE - decay_rate); both stay within +/-ONE.
    localparam int COEF_W = (FRAC_BITS + 2 > DECAY_W + 2) ? FRAC_BITS + 2 : DECAY_W + 2;
    localparam int PROD_W = COEF_W + FIELD_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int TC_W   = SUM_W - FRAC_BITS;
    localparam int NPROD_W = 2 * FIELD_W;

    localparam logic signed [NPROD_W-1:0] ONE_WIDE = NPROD_W'(1) << FRAC_BITS;
    localparam logic signed [COEF_W-1:0]  ONE_COEF = COEF_W'(1) << FRAC_BITS;
    localparam int STRENGTH_MAX = (1 << (FIELD_W - 1)) - 1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CONVERT_LINKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONV_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCUS_BOUNDARY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_RATE = 2'd3;

    // Reset values of the configuration registers.
    localparam logic                      RST_CONVERT_LINKS  = 1'b0;
    localparam logic signed [FIELD_W-1:0] RST_CONV_THRESHOLD = 16'sd15;
    localparam logic signed [FIELD_W-1:0] RST_FOCUS_BOUNDARY = 16'sd0;
    localparam logic [DECAY_W-1:0]        RST_DECAY_RATE     = 15'd1638;

    // Per-item decision flags carried down the pipeline.
    typedef struct packed {
        logic kind;
        logic nf_neg;
        logic nf_le0;
        logic ns_pos;
        logic conv;
    } hlsu_flags_t;

    // One result word.
    typedef struct packed {
        logic signed [FIELD_W-1:0] strength;
        logic                      kind;
        logic                      rebuilt;
        logic                      conf;
        logic                      swap;
        logic                      missing;
    } hlsu_result_t;

endpackage

// ===== design/hlsu_decide.sv =====
`timescale 1ns / 1ps

module hlsu_decide import hlsu_pkg::*; (
    input  hlsu_flags_t               flags,
    input  logic signed [PROD_W-1:0]  prod_new,
    input  logic signed [PROD_W-1:0]  prod_old,
    output hlsu_result_t              result
);

    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] sum_sh;
    logic signed [TC_W-1:0]  tc;
    logic signed [TC_W:0]    tc_ext;
    logic signed [TC_W:0]    mag;
    logic                    tc_neg;
    logic                    inv_pos;
    logic                    rebuild;

    // Blend sum and floor division by ONE.
    always_comb begin
        sum    = $signed({prod_new[PROD_W-1], prod_new}) + $signed({prod_old[PROD_W-1], prod_old});
        sum_sh = sum >>> FRAC_BITS;
        tc     = $signed(sum_sh[TC_W-1:0]);
        tc_ext = $signed({tc[TC_W-1], tc});
        tc_neg = tc[TC_W-1];
    end

    // A negative blend either rebuilds the link or is floored at zero.
    always_comb begin
        inv_pos = flags.kind & ~flags.nf_neg;
        rebuild = flags.conv & tc_neg;
        if (!tc_neg) begin
            mag = tc_ext;
        end else if (flags.conv) begin
            mag = -tc_ext;
        end else begin
            mag = '0;
        end
    end

    // Saturate and assemble the result word.
    always_comb begin
        if (mag > (TC_W + 1)'(STRENGTH_MAX)) begin
            result.strength = FIELD_W'(STRENGTH_MAX);
        end else begin
            result.strength = $signed(mag[FIELD_W-1:0]);
        end
        result.rebuilt = rebuild;
        result.kind    = rebuild ? ~inv_pos : flags.kind;
        result.conf    = rebuild & inv_pos;
        result.swap    = rebuild & ~inv_pos & flags.ns_pos;
        result.missing = rebuild & ~inv_pos & ~flags.ns_pos & flags.nf_le0;
    end

endmodule

// ===== design/hebbian_link_strength_update_core.sv =====
`timescale 1ns / 1ps

// Hebbian link strength update: one link word in, one result word out. The
// core is a three-stage pipeline (normalized product, blend multipliers,
// sum and decision into the output register), so it takes one word per clock
// while the output side is ready. A result passes the stage 1, stage 2 and
// output registers and is taken when the output side is ready. Back-pressure
// stalls each stage only as far as it is full. Configuration registers are
// written through cfg_we/cfg_addr/cfg_wdata and must only change while no word
// is in flight.
module hebbian_link_strength_update_core import hlsu_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_addr,
    input  logic [FIELD_W-1:0]           cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_link_kind,
    input  logic signed [FIELD_W-1:0]    s_old_strength,
    input  logic signed [FIELD_W-1:0]    s_importance_first,
    input  logic signed [FIELD_W-1:0]    s_importance_second,
    input  logic signed [FIELD_W-1:0]    s_norm_first,
    input  logic signed [FIELD_W-1:0]    s_norm_second,
    input  logic signed [FIELD_W-1:0]    s_long_importance,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [FIELD_W-1:0]    m_new_strength,
    output logic                         m_new_kind,
    output logic                         m_rebuilt,
    output logic                         m_new_confidence,
    output logic                         m_swap_targets,
    output logic                         m_source_missing
);

    // Configuration registers.
    logic                      convert_reg;
    logic signed [FIELD_W-1:0] threshold_reg;
    logic signed [FIELD_W-1:0] focus_reg;
    logic [DECAY_W-1:0]        decay_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            convert_reg   <= RST_CONVERT_LINKS;
            threshold_reg <= RST_CONV_THRESHOLD;
            focus_reg     <= RST_FOCUS_BOUNDARY;
            decay_reg     <= RST_DECAY_RATE;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_CONVERT_LINKS:  convert_reg   <= cfg_wdata[0];
                CFG_CONV_THRESHOLD: threshold_reg <= $signed(cfg_wdata);
                CFG_FOCUS_BOUNDARY: focus_reg     <= $signed(cfg_wdata);
                CFG_DECAY_RATE:     decay_reg     <= cfg_wdata[DECAY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Stage valid bits and the ready chain from the output side back.
    logic v1_reg, v2_reg, v3_reg;
    logic rdy1, rdy2, rdy3;

    assign rdy3    = ~v3_reg | m_ready;
    assign rdy2    = ~v2_reg | rdy3;
    assign rdy1    = ~v1_reg | rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage 1: attention test, conversion enable and the normalized product.
    hlsu_flags_t               flags1_next, flags1_reg;
    logic                      attn1_next, attn1_reg;
    logic signed [NPROD_W-1:0] nprod1_next, nprod1_reg;
    logic signed [FIELD_W-1:0] old1_reg;

    always_comb begin
        attn1_next = (s_importance_first > focus_reg) || (s_importance_second > focus_reg);
        flags1_next.kind   = s_link_kind;
        flags1_next.nf_neg = s_norm_first[FIELD_W-1];
        flags1_next.nf_le0 = s_norm_first[FIELD_W-1] || (s_norm_first == '0);
        flags1_next.ns_pos = ~s_norm_second[FIELD_W-1] && (s_norm_second != '0);
        flags1_next.conv   = convert_reg && (s_long_importance < threshold_reg);
        nprod1_next = s_norm_first * s_norm_second;
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            flags1_reg <= flags1_next;
            attn1_reg  <= attn1_next;
            nprod1_reg <= nprod1_next;
            old1_reg   <= s_old_strength;
        end
    end

    // Stage 2: clamp the conjunction, pick its sign, run both blend multipliers.
    logic signed [NPROD_W-1:0] conj_full;
    logic signed [NPROD_W-1:0] conj_clamp;
    logic signed [COEF_W-1:0]  conj;
    logic signed [COEF_W-1:0]  conj_sel;
    logic signed [COEF_W-1:0]  keep_coef;
    logic                      negate;
    logic signed [PROD_W-1:0]  pnew2_next, pnew2_reg;
    logic signed [PROD_W-1:0]  pold2_next, pold2_reg;
    hlsu_flags_t               flags2_reg;

    always_comb begin
        conj_full = nprod1_reg >>> FRAC_BITS;
        if (conj_full > ONE_WIDE) begin
            conj_clamp = ONE_WIDE;
        end else if (conj_full < -ONE_WIDE) begin
            conj_clamp = -ONE_WIDE;
        end else begin
            conj_clamp = conj_full;
        end
        conj = attn1_reg ? $signed(conj_clamp[COEF_W-1:0]) : '0;
        // Inverse links subtract the conjunction on the side opposite the source.
        if (flags1_reg.conv) begin
            negate = flags1_reg.kind & ~flags1_reg.nf_neg;
        end else begin
            negate = flags1_reg.kind & flags1_reg.nf_neg;
        end
        conj_sel   = negate ? -conj : conj;
        keep_coef  = ONE_COEF - $signed(COEF_W'(decay_reg));
        pnew2_next = $signed({1'b0, decay_reg}) * conj_sel;
        pold2_next = keep_coef * old1_reg;
    end

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            flags2_reg <= flags1_reg;
            pnew2_reg  <= pnew2_next;
            pold2_reg  <= pold2_next;
        end
    end

    // Stage 3: blend sum and decision into the output register.
    hlsu_result_t res3_next, res3_reg;

    hlsu_decide u_decide (
        .flags    (flags2_reg),
        .prod_new (pnew2_reg),
        .prod_old (pold2_reg),
        .result   (res3_next)
    );

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            res3_reg <= res3_next;
        end
    end

    assign m_valid          = v3_reg;
    assign m_new_strength   = res3_reg.strength;
    assign m_new_kind       = res3_reg.kind;
    assign m_rebuilt        = res3_reg.rebuilt;
    assign m_new_confidence = res3_reg.conf;
    assign m_swap_targets   = res3_reg.swap;
    assign m_source_missing = res3_reg.missing;

endmodule

// ===== design/hlsu_checker.sv =====
`timescale 1ns / 1ps

`include "hebbian_link_strength_update_core_assert.svh"

module hlsu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_new_strength,
    input logic        m_new_kind,
    input logic        m_rebuilt,
    input logic        m_new_confidence,
    input logic        m_swap_targets,
    input logic        m_source_missing
);

    // A stalled result word holds its value.
    `HLSU_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_new_strength) && $stable(m_rebuilt), "result word changed while stalled")

    // Reordering and confidence are only reported for a recreated link.
    `HLSU_ASSERT_SAME(a_plain_flags, m_valid && !m_rebuilt, !m_new_confidence && !m_swap_targets && !m_source_missing, "reorder flags set without rebuild")

    // A swap only happens on a link recreated as inverse, and then a source exists.
    `HLSU_ASSERT_SAME(a_swap_kind, m_valid && m_swap_targets, m_new_kind && !m_source_missing && !m_new_confidence, "swap on wrong kind")

    // Strength is never negative after an update.
    `HLSU_ASSERT_SAME(a_strength_sign, m_valid, !m_new_strength[15], "negative strength")

endmodule

bind hebbian_link_strength_update_core hlsu_checker u_hlsu_checker (.*);

// ===== verif/hlsu_update_monitor.sv =====
`timescale 1ns / 1ps

// Watches the link and result channels of the update core, predicts each
// result word from the accepted link word and the current register values,
// and compares the two in order.
module hlsu_update_monitor import hlsu_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_addr,
    input  logic [FIELD_W-1:0]        cfg_wdata,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic                      s_link_kind,
    input  logic signed [FIELD_W-1:0] s_old_strength,
    input  logic signed [FIELD_W-1:0] s_importance_first,
    input  logic signed [FIELD_W-1:0] s_importance_second,
    input  logic signed [FIELD_W-1:0] s_norm_first,
    input  logic signed [FIELD_W-1:0] s_norm_second,
    input  logic signed [FIELD_W-1:0] s_long_importance,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic signed [FIELD_W-1:0] m_new_strength,
    input  logic                      m_new_kind,
    input  logic                      m_rebuilt,
    input  logic                      m_new_confidence,
    input  logic                      m_swap_targets,
    input  logic                      m_source_missing,
    output int                        pending_words,
    output int                        fail_words
);

    // Shadow copy of the configuration registers.
    logic                      convert_en;
    logic signed [FIELD_W-1:0] conv_thr;
    logic signed [FIELD_W-1:0] focus_lvl;
    logic [DECAY_W-1:0]        decay_w;

    hlsu_result_t expected_updates[$];
    hlsu_result_t exp_r;
    hlsu_result_t got_r;
    int           fail_total = 0;

    // Blend of a conjunction term with the old strength, floored.
    function automatic longint blend_strength(input longint conj_term, input longint old_v);
        longint one;
        longint rate;
        one = longint'(1) << FRAC_BITS;
        rate = longint'(decay_w);
        return (rate * conj_term + (one - rate) * old_v) >>> FRAC_BITS;
    endfunction

    // Expected result word for one link word under the current registers.
    function automatic hlsu_result_t predict_link_update(
        input logic                      kind,
        input logic signed [FIELD_W-1:0] old_s,
        input logic signed [FIELD_W-1:0] imp_a,
        input logic signed [FIELD_W-1:0] imp_b,
        input logic signed [FIELD_W-1:0] nf,
        input logic signed [FIELD_W-1:0] ns,
        input logic signed [FIELD_W-1:0] lti
    );
        longint       one;
        longint       conj;
        longint       blended;
        longint       strength;
        logic         reorder;
        hlsu_result_t r;
        one = longint'(1) << FRAC_BITS;
        conj = 0;
        reorder = 1'b0;
        r = '0;
        r.kind = kind;

        // Conjunction counts only when a target is in attention.
        if (imp_a > focus_lvl || imp_b > focus_lvl) begin
            conj = (longint'(nf) * longint'(ns)) >>> FRAC_BITS;
            if (conj > one) conj = one;
            if (conj < -one) conj = -one;
        end

        if (convert_en && lti < conv_thr) begin
            // A negative blend recreates the link; only an inverse link with a non-negative source becomes symmetric.
            if (kind && nf < 0) begin
                blended = blend_strength(conj, longint'(old_s));
                reorder = blended < 0;
            end else if (kind) begin
                blended = blend_strength(-conj, longint'(old_s));
            end else begin
                blended = blend_strength(conj, longint'(old_s));
                reorder = blended < 0;
            end
            if (blended < 0) begin
                strength = -blended;
                r.rebuilt = 1'b1;
                r.kind = reorder;
                r.conf = !reorder;
            end else begin
                strength = blended;
            end
        end else begin
            // No conversion: inverse links with a negative source see -c.
            blended = blend_strength((kind && nf < 0) ? -conj : conj, longint'(old_s));
            strength = (blended < 0) ? 0 : blended;
        end

        // Source reordering of a link recreated as inverse.
        if (reorder) begin
            if (ns > 0) r.swap = 1'b1;
            else if (nf <= 0) r.missing = 1'b1;
        end

        if (strength > 32767) strength = 32767;
        if (strength < -32768) strength = -32768;
        r.strength = FIELD_W'(strength);
        return r;
    endfunction

    task automatic report_field(input string field_name, input longint exp_val,
                                input longint got_val);
        if (exp_val != got_val) begin
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, field_name, exp_val, got_val);
            fail_total++;
        end
    endtask

    // Track register writes, check result words, queue predictions.
    always @(posedge aclk) begin
        if (!aresetn) begin
            convert_en = RST_CONVERT_LINKS;
            conv_thr = RST_CONV_THRESHOLD;
            focus_lvl = RST_FOCUS_BOUNDARY;
            decay_w = RST_DECAY_RATE;
            expected_updates.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_CONVERT_LINKS: convert_en = cfg_wdata[0];
                    CFG_CONV_THRESHOLD: conv_thr = cfg_wdata;
                    CFG_FOCUS_BOUNDARY: focus_lvl = cfg_wdata;
                    CFG_DECAY_RATE: decay_w = cfg_wdata[DECAY_W-1:0];
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                got_r.strength = m_new_strength;
                got_r.kind = m_new_kind;
                got_r.rebuilt = m_rebuilt;
                got_r.conf = m_new_confidence;
                got_r.swap = m_swap_targets;
                got_r.missing = m_source_missing;
                if (expected_updates.size() == 0) begin
                    $display("%0t: result word with none expected, expected nothing, got %0d",
                             $time, got_r.strength);
                    fail_total++;
                end else begin
                    exp_r = expected_updates.pop_front();
                    report_field("new_strength", exp_r.strength, got_r.strength);
                    report_field("new_kind", exp_r.kind, got_r.kind);
                    report_field("rebuilt", exp_r.rebuilt, got_r.rebuilt);
                    report_field("new_confidence", exp_r.conf, got_r.conf);
                    report_field("swap_targets", exp_r.swap, got_r.swap);
                    report_field("source_missing", exp_r.missing, got_r.missing);
                end
            end

            if (s_valid && s_ready)
                expected_updates.insert(expected_updates.size(), predict_link_update(
                    s_link_kind, s_old_strength, s_importance_first,
                    s_importance_second, s_norm_first, s_norm_second,
                    s_long_importance));
        end
        pending_words <= expected_updates.size();
        fail_words <= fail_total;
    end

endmodule

// ===== verif/hebbian_link_strength_update_core_tb.sv =====
`timescale 1ns / 1ps

module hebbian_link_strength_update_core_tb;
    import hlsu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int WORDS_PER_SETTING = 56;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_addr = CFG_CONVERT_LINKS;
    logic [FIELD_W-1:0]        cfg_wdata = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_link_kind = 1'b0;
    logic signed [FIELD_W-1:0] s_old_strength = '0;
    logic signed [FIELD_W-1:0] s_importance_first = '0;
    logic signed [FIELD_W-1:0] s_importance_second = '0;
    logic signed [FIELD_W-1:0] s_norm_first = '0;
    logic signed [FIELD_W-1:0] s_norm_second = '0;
    logic signed [FIELD_W-1:0] s_long_importance = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [FIELD_W-1:0] m_new_strength;
    logic                      m_new_kind;
    logic                      m_rebuilt;
    logic                      m_new_confidence;
    logic                      m_swap_targets;
    logic                      m_source_missing;

    int pending_words;
    int fail_words;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int cur_thr = 15;
    int cur_focus = 0;
    int cycle_count = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    hebbian_link_strength_update_core i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_link_kind(s_link_kind),
        .s_old_strength(s_old_strength),
        .s_importance_first(s_importance_first),
        .s_importance_second(s_importance_second),
        .s_norm_first(s_norm_first),
        .s_norm_second(s_norm_second),
        .s_long_importance(s_long_importance),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_new_strength(m_new_strength),
        .m_new_kind(m_new_kind),
        .m_rebuilt(m_rebuilt),
        .m_new_confidence(m_new_confidence),
        .m_swap_targets(m_swap_targets),
        .m_source_missing(m_source_missing)
    );

    hlsu_update_monitor i_update_monitor (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_link_kind(s_link_kind),
        .s_old_strength(s_old_strength),
        .s_importance_first(s_importance_first),
        .s_importance_second(s_importance_second),
        .s_norm_first(s_norm_first),
        .s_norm_second(s_norm_second),
        .s_long_importance(s_long_importance),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_new_strength(m_new_strength),
        .m_new_kind(m_new_kind),
        .m_rebuilt(m_rebuilt),
        .m_new_confidence(m_new_confidence),
        .m_swap_targets(m_swap_targets),
        .m_source_missing(m_source_missing),
        .pending_words(pending_words),
        .fail_words(fail_words)
    );

    // Result side back-pressure.
    always @(posedge aclk) begin
        m_ready <= (int'($urandom_range(0, 99)) >= sink_stall_pct);
    end

    // Run limit.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("hebbian_link_strength_update_core_tb: FAIL");
        $finish;
    end

    function automatic int rand16();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Offer one link word and hold it until it is taken.
    task automatic send_link(input bit kind, input int old_v, input int imp_a,
                             input int imp_b, input int nf, input int ns,
                             input int lti);
        while (int'($urandom_range(0, 99)) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_link_kind <= kind;
        s_old_strength <= FIELD_W'(old_v);
        s_importance_first <= FIELD_W'(imp_a);
        s_importance_second <= FIELD_W'(imp_b);
        s_norm_first <= FIELD_W'(nf);
        s_norm_second <= FIELD_W'(ns);
        s_long_importance <= FIELD_W'(lti);
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= FIELD_W'(data);
        @(posedge aclk);
    endtask

    // Wait until every result word in flight has been checked.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0) @(posedge aclk);
    endtask

    task automatic apply_setting(input bit conv, input int thr, input int focus,
                                 input int decay);
        write_reg(CFG_CONVERT_LINKS, conv);
        write_reg(CFG_CONV_THRESHOLD, thr);
        write_reg(CFG_FOCUS_BOUNDARY, focus);
        write_reg(CFG_DECAY_RATE, decay);
        cfg_we <= 1'b0;
        cur_thr = thr;
        cur_focus = focus;
    endtask

    // Importance: half the time right around the focus boundary, else anywhere.
    function automatic int pick_importance();
        int v;
        if ($urandom_range(0, 1)) begin
            v = cur_focus + int'($urandom_range(0, 4)) - 2;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v;
        end
        return rand16();
    endfunction

    // Normalized importance: mostly in [-1,1], sometimes the edges or anything.
    function automatic int pick_norm();
        case ($urandom_range(0, 7))
            0: return rand16();
            1: return ($urandom_range(0, 2) == 0) ? 0 :
                      ($urandom_range(0, 1) ? 16384 : -16384);
            default: return int'($urandom_range(0, 32768)) - 16384;
        endcase
    endfunction

    // Long-term importance: half the time below the conversion threshold.
    function automatic int pick_long_importance();
        if ($urandom_range(0, 1) && cur_thr > -32768)
            return -32768 + int'($urandom_range(0, cur_thr + 32767));
        return rand16();
    endfunction

    task automatic send_random_link();
        int imp_a;
        int imp_b;
        int nf;
        int ns;
        int lti;
        imp_a = pick_importance();
        imp_b = pick_importance();
        nf = pick_norm();
        ns = pick_norm();
        lti = pick_long_importance();
        send_link(1'($urandom_range(0, 1)), rand16(), imp_a, imp_b, nf, ns, lti);
    endtask

    // Stimulus and verdict.
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words with conversion on and an even blend.
        apply_setting(1'b1, 32767, 0, 8192);
        send_link(0, 0, 100, -5, 16384, -16384, 0);        // recreated, order kept
        send_link(0, 0, -5, 100, -16384, 16384, 0);        // recreated, swapped
        send_link(0, -32768, 1, 1, 4096, 4096, 0);         // both positive, swapped
        send_link(0, -1000, 1, 1, 0, 0, 0);                // no positive source
        send_link(0, -1000, 1, 1, -300, -300, 0);          // no positive source
        send_link(1, -20000, 1, 1, -16384, 16384, 0);      // inverse reversed
        send_link(1, 20000, 1, 1, -8192, 8192, 0);         // inverse, blend kept
        send_link(1, -20000, 1, 1, 8192, 8192, 0);         // inverse to symmetric
        send_link(1, 20000, 1, 1, 8192, 8192, 0);
        send_link(0, 100, 0, -32768, 16384, 16384, 0);     // out of attention
        send_link(0, 0, 32767, 32767, 32767, 32767, 0);    // clamp high
        send_link(0, 0, 32767, 1, -32768, 32767, 0);       // clamp low
        send_link(0, 0, 1, 1, -32768, -32768, -32768);
        send_link(0, -32768, 1, 1, -16384, 16384, 32767);  // threshold not met
        send_link(1, 32767, 1, 1, -16384, -16384, 0);
        wait_drained();

        // Nothing in attention, decay rate above one, no conversion.
        apply_setting(1'b0, -32768, 32767, 32767);
        send_link(0, -32768, 32767, 32767, 16384, 16384, -32768); // sign flipped by the keep term
        send_link(1, 32767, 32767, 0, -16384, 16384, 32767);      // floored
        send_link(1, -1, -32768, -32768, -1, -1, 0);
        wait_drained();

        // Decay rate zero: the blend is the old strength.
        apply_setting(1'b1, 32767, -32768, 0);
        send_link(0, -32768, 5, 5, 16384, 16384, -32768);  // strength overflows
        send_link(1, -32768, 5, 5, 16384, 16384, 0);
        send_link(1, 32767, 5, 5, -16384, 16384, 0);
        wait_drained();

        // Random words, two settings per idling phase.
        for (int k = 0; k < 8; k++) begin
            case (k / 2)
                0: begin src_idle_pct = 0; sink_stall_pct = 0; end
                1: begin src_idle_pct = 88; sink_stall_pct = 0; end
                2: begin src_idle_pct = 0; sink_stall_pct = 88; end
                default: begin src_idle_pct = 20; sink_stall_pct = 20; end
            endcase
            case (k)
                0: apply_setting(1'b1, 15, 0, 1638);
                1: apply_setting(1'b0, 15, 0, 1638);
                2: apply_setting(1'b1, 32767, -32768, 16384);
                3: apply_setting(1'b1, -32768, 32767, 0);
                4: apply_setting(1'b1, 32767, 0, 32767);
                5: apply_setting(1'($urandom_range(0, 1)), rand16(), rand16(),
                                 $urandom_range(0, 16384));
                6: apply_setting(1'b1, rand16(), rand16(), $urandom_range(0, 16384));
                default: apply_setting(1'($urandom_range(0, 1)), rand16(), rand16(),
                                       $urandom_range(0, 32767));
            endcase
            repeat (WORDS_PER_SETTING) send_random_link();
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (fail_words == 0) begin
            $display("hebbian_link_strength_update_core_tb: PASS");
        end else begin
            $display("hebbian_link_strength_update_core_tb: FAIL");
        end
        $finish;
    end

endmodule
